/* design/csssel_pkg.sv */
package csssel_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] spec_max;
    logic        saturated;
  } out_beat_t;

  // scorer modes
  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_NAME    = 3'd1;
  localparam logic [2:0] MODE_BRACKET = 3'd2;
  localparam logic [2:0] MODE_COLON   = 3'd3;
  localparam logic [2:0] MODE_PSEUDO  = 3'd4;
  localparam logic [2:0] MODE_PAREN   = 3'd5;

  // quote state
  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
  localparam logic [1:0] QUOTE_SINGLE = 2'd2;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [6:0] SCORE_ID    = 7'd100;
  localparam logic [6:0] SCORE_CLASS = 7'd10;
  localparam logic [6:0] SCORE_TYPE  = 7'd1;

  function automatic logic is_name_start(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           c == 8'h5f || c == 8'h2d;
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_name_start(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

/* design/csssel_splitter.sv */
module csssel_splitter #(
  parameter int NEST_WIDTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       split_o
);
  import csssel_pkg::*;

  localparam logic [NEST_WIDTH-1:0] NestMax = '1;

  logic [NEST_WIDTH-1:0] paren_q, paren_d;
  logic [NEST_WIDTH-1:0] bracket_q, bracket_d;
  logic [1:0]            quote_q, quote_d;
  logic                  esc_q, esc_d;
  logic                  in_quote;

  // an unused quote code counts as no quote
  assign in_quote = (quote_q == QUOTE_DOUBLE) || (quote_q == QUOTE_SINGLE);

  always_comb begin
    paren_d   = paren_q;
    bracket_d = bracket_q;
    quote_d   = in_quote ? quote_q : QUOTE_NONE;
    esc_d     = 1'b0;
    split_o   = 1'b0;
    priority if (esc_q) begin
      esc_d = 1'b0;
    end else if (byte_i == CH_BSLASH) begin
      esc_d = 1'b1;
    end else if (in_quote) begin
      if ((quote_q == QUOTE_DOUBLE && byte_i == CH_DQUOTE) ||
          (quote_q == QUOTE_SINGLE && byte_i == CH_SQUOTE)) begin
        quote_d = QUOTE_NONE;
      end
    end else if (byte_i == CH_DQUOTE) begin
      quote_d = QUOTE_DOUBLE;
    end else if (byte_i == CH_SQUOTE) begin
      quote_d = QUOTE_SINGLE;
    end else if (byte_i == CH_LPAREN) begin
      if (paren_q != NestMax) paren_d = paren_q + 1'b1;
    end else if (byte_i == CH_RPAREN && paren_q != '0) begin
      paren_d = paren_q - 1'b1;
    end else if (byte_i == CH_LBRACK) begin
      if (bracket_q != NestMax) bracket_d = bracket_q + 1'b1;
    end else if (byte_i == CH_RBRACK && bracket_q != '0) begin
      bracket_d = bracket_q - 1'b1;
    end else if (byte_i == CH_COMMA && paren_q == '0 && bracket_q == '0) begin
      split_o = 1'b1;
    end else begin
      split_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paren_q   <= '0;
      bracket_q <= '0;
      quote_q   <= QUOTE_NONE;
      esc_q     <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        paren_q   <= '0;
        bracket_q <= '0;
        quote_q   <= QUOTE_NONE;
        esc_q     <= 1'b0;
      end else begin
        paren_q   <= paren_d;
        bracket_q <= bracket_d;
        quote_q   <= quote_d;
        esc_q     <= esc_d;
      end
    end
  end

endmodule

/* design/csssel_scorer.sv */
module csssel_scorer #(
  parameter int SCORE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             byte_i,
  input  logic                   split_i,
  input  logic                   last_i,
  output logic [SCORE_WIDTH-1:0] best_o,
  output logic                   ovf_o
);
  import csssel_pkg::*;

  localparam logic [SCORE_WIDTH-1:0] ScoreMax = '1;

  logic [2:0]             mode_q, mode_d, mode_eff;
  logic                   type_q, type_d;
  logic [SCORE_WIDTH-1:0] cur_q, cur_d;
  logic [SCORE_WIDTH-1:0] best_q, best_d;
  logic                   ovf_q, ovf_d;
  logic                   classify;
  logic [6:0]             add_val;
  logic [SCORE_WIDTH:0]   sum_w;
  logic [SCORE_WIDTH-1:0] cur_max;

  assign cur_max = (cur_q > best_q) ? cur_q : best_q;
  assign sum_w   = {1'b0, cur_q} + (SCORE_WIDTH+1)'(add_val);

  always_comb begin
    mode_d   = mode_q;
    type_d   = type_q;
    mode_eff = mode_q;
    classify = 1'b0;
    add_val  = '0;
    if (!split_i) begin
      priority if (mode_q == MODE_BRACKET) begin
        if (byte_i == CH_RBRACK) mode_d = MODE_NORMAL;
      end else if (mode_q == MODE_PAREN) begin
        if (byte_i == CH_RPAREN) mode_d = MODE_NORMAL;
      end else begin
        classify = 1'b1;
        // second colon of a pseudo-element is swallowed
        if (mode_q == MODE_COLON) begin
          mode_eff = MODE_PSEUDO;
          if (byte_i == CH_COLON) begin
            mode_d   = MODE_PSEUDO;
            classify = 1'b0;
          end
        end
        if (classify && mode_eff == MODE_PSEUDO) begin
          if (is_name_char(byte_i)) begin
            mode_d   = MODE_PSEUDO;
            classify = 1'b0;
          end else if (byte_i == CH_LPAREN) begin
            mode_d   = MODE_PAREN;
            classify = 1'b0;
          end
        end
        if (classify && mode_eff == MODE_NAME && is_name_char(byte_i)) begin
          classify = 1'b0;
        end
        if (classify) begin
          mode_d = MODE_NORMAL;
          priority if (is_space(byte_i) || byte_i == CH_GT || byte_i == CH_PLUS ||
                       byte_i == CH_TILDE) begin
            type_d = 1'b1;
          end else if (byte_i == CH_HASH) begin
            add_val = SCORE_ID;
            type_d  = 1'b0;
            mode_d  = MODE_NAME;
          end else if (byte_i == CH_DOT) begin
            add_val = SCORE_CLASS;
            type_d  = 1'b0;
            mode_d  = MODE_NAME;
          end else if (byte_i == CH_LBRACK) begin
            add_val = SCORE_CLASS;
            type_d  = 1'b0;
            mode_d  = MODE_BRACKET;
          end else if (byte_i == CH_COLON) begin
            add_val = SCORE_CLASS;
            type_d  = 1'b0;
            mode_d  = MODE_COLON;
          end else if (type_q && is_name_start(byte_i)) begin
            add_val = SCORE_TYPE;
            type_d  = 1'b0;
            mode_d  = MODE_NAME;
          end else begin
            type_d = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    cur_d  = cur_q;
    best_d = best_q;
    ovf_d  = ovf_q;
    if (split_i) begin
      cur_d  = '0;
      best_d = cur_max;
    end else if (add_val != '0) begin
      if (sum_w >= {1'b0, ScoreMax}) begin
        cur_d = ScoreMax;
        ovf_d = 1'b1;
      end else begin
        cur_d = sum_w[SCORE_WIDTH-1:0];
      end
    end
  end

  // closing of the last selector at the end of the list
  assign best_o = (cur_d > best_d) ? cur_d : best_d;
  assign ovf_o  = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      type_q <= 1'b1;
      cur_q  <= '0;
      best_q <= '0;
      ovf_q  <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        mode_q <= MODE_NORMAL;
        type_q <= 1'b1;
        cur_q  <= '0;
        best_q <= '0;
        ovf_q  <= 1'b0;
      end else if (split_i) begin
        mode_q <= MODE_NORMAL;
        type_q <= 1'b1;
        cur_q  <= cur_d;
        best_q <= best_d;
        ovf_q  <= ovf_d;
      end else begin
        mode_q <= mode_d;
        type_q <= type_d;
        cur_q  <= cur_d;
        best_q <= best_d;
        ovf_q  <= ovf_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> cur_q == '0 && best_q == '0 && type_q && !ovf_q)
    else $error("scorer state not cleared after end of list");
  a_split_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && split_i && !last_i |=> cur_q == '0 && mode_q == MODE_NORMAL)
    else $error("selector sum not cleared at split comma");
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= MODE_PAREN)
    else $error("scorer mode out of range");
  a_ovf_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(ovf_q) && $stable(best_q))
    else $error("scorer state moved without an accepted beat");
`endif

endmodule

/* design/css_selector_list_specificity_top.sv */
// a result is registered and shown in the cycle after its final byte is accepted
// throughput: one byte per cycle unless a final byte waits for the output slot
// a non-final byte is taken even while a result waits; a final byte waits for the slot
// reset: asynchronous active low, clears nesting, quote, scorer and output valid state
module css_selector_list_specificity_top #(
  parameter int NEST_WIDTH  = 8,
  parameter int SCORE_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  csssel_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output csssel_pkg::out_beat_t out_data_o
);
  import csssel_pkg::*;

  logic                   accept;
  logic                   split;
  logic [SCORE_WIDTH-1:0] best;
  logic                   ovf;
  logic [31:0]            best_wide;
  logic                   out_valid_q;
  out_beat_t              out_data_q, out_data_d;

  assign in_ready_o = !out_valid_q || out_ready_i || !in_data_i.final_byte;
  assign accept     = in_valid_i && in_ready_o;

  csssel_splitter #(
    .NEST_WIDTH(NEST_WIDTH)
  ) u_splitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (in_data_i.text_byte),
    .last_i  (in_data_i.final_byte),
    .split_o (split)
  );

  csssel_scorer #(
    .SCORE_WIDTH(SCORE_WIDTH)
  ) u_scorer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (in_data_i.text_byte),
    .split_i (split),
    .last_i  (in_data_i.final_byte),
    .best_o  (best),
    .ovf_o   (ovf)
  );

  // clamp to the 16-bit result field
  assign best_wide = 32'(best);
  always_comb begin
    if (best_wide[31:16] != '0) begin
      out_data_d.spec_max  = 16'hffff;
      out_data_d.saturated = 1'b1;
    end else begin
      out_data_d.spec_max  = best_wide[15:0];
      out_data_d.saturated = ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_data_i.final_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.final_byte) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csssel_pkg::*;

  localparam int NEST_W = 8;
  localparam int SCORE_W = 16;
  localparam int unsigned NEST_LIMIT = (1 << NEST_W) - 1;
  localparam longint unsigned SCORE_LIMIT = (64'd1 << SCORE_W) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 600;
  localparam string NAME_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  css_selector_list_specificity_top #(
    .NEST_WIDTH (NEST_W),
    .SCORE_WIDTH(SCORE_W)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_beat)
  );

  always #5 clk = ~clk;

  // splitter and scorer state of the predictor
  int unsigned     paren_lvl;
  int unsigned     bracket_lvl;
  logic [1:0]      quote_state;
  logic            escape_state;
  logic [2:0]      scan_state;
  logic            type_allowed;
  longint unsigned selector_score;
  longint unsigned best_score;
  logic            score_clipped;

  out_beat_t   specificity_q[$];
  logic [7:0]  text_q[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_request = 0;
  int          random_sent = 0;

  function automatic logic letter_or_mark(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "-";
  endfunction

  function automatic logic ident_char(input logic [7:0] c);
    return letter_or_mark(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic logic white_char(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_state();
    paren_lvl      = 0;
    bracket_lvl    = 0;
    quote_state    = QUOTE_NONE;
    escape_state   = 1'b0;
    scan_state     = MODE_NORMAL;
    type_allowed   = 1'b1;
    selector_score = 0;
    best_score     = 0;
    score_clipped  = 1'b0;
  endfunction

  function automatic void add_points(input int unsigned pts);
    longint unsigned s;
    s = selector_score + pts;
    if (s >= SCORE_LIMIT) begin
      s = SCORE_LIMIT;
      score_clipped = 1'b1;
    end
    selector_score = s;
  endfunction

  function automatic void end_selector();
    if (selector_score > best_score) best_score = selector_score;
    selector_score = 0;
    type_allowed   = 1'b1;
    scan_state     = MODE_NORMAL;
  endfunction

  // returns 1 on an unescaped comma outside quotes, parens and brackets
  function automatic logic split_char(input logic [7:0] c);
    if (escape_state) begin
      escape_state = 1'b0;
      return 1'b0;
    end
    if (c == CH_BSLASH) begin
      escape_state = 1'b1;
      return 1'b0;
    end
    if (quote_state != QUOTE_NONE) begin
      if ((quote_state == QUOTE_DOUBLE && c == CH_DQUOTE) ||
          (quote_state == QUOTE_SINGLE && c == CH_SQUOTE)) quote_state = QUOTE_NONE;
      return 1'b0;
    end
    if (c == CH_DQUOTE) begin
      quote_state = QUOTE_DOUBLE;
    end else if (c == CH_SQUOTE) begin
      quote_state = QUOTE_SINGLE;
    end else if (c == CH_LPAREN) begin
      if (paren_lvl < NEST_LIMIT) paren_lvl++;
    end else if (c == CH_RPAREN && paren_lvl > 0) begin
      paren_lvl--;
    end else if (c == CH_LBRACK) begin
      if (bracket_lvl < NEST_LIMIT) bracket_lvl++;
    end else if (c == CH_RBRACK && bracket_lvl > 0) begin
      bracket_lvl--;
    end else if (c == CH_COMMA && paren_lvl == 0 && bracket_lvl == 0) begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void score_char(input logic [7:0] c);
    logic nm;
    nm = ident_char(c);
    if (scan_state == MODE_BRACKET) begin
      if (c == CH_RBRACK) scan_state = MODE_NORMAL;
      return;
    end
    if (scan_state == MODE_PAREN) begin
      if (c == CH_RPAREN) scan_state = MODE_NORMAL;
      return;
    end
    if (scan_state == MODE_COLON) begin
      scan_state = MODE_PSEUDO;
      if (c == CH_COLON) return;
    end
    if (scan_state == MODE_PSEUDO) begin
      if (nm) return;
      if (c == CH_LPAREN) begin
        scan_state = MODE_PAREN;
        return;
      end
    end
    if (scan_state == MODE_NAME && nm) return;
    scan_state = MODE_NORMAL;

    if (white_char(c) || c == CH_GT || c == CH_PLUS || c == CH_TILDE) begin
      type_allowed = 1'b1;
    end else if (c == CH_HASH) begin
      add_points(SCORE_ID);
      type_allowed = 1'b0;
      scan_state   = MODE_NAME;
    end else if (c == CH_DOT) begin
      add_points(SCORE_CLASS);
      type_allowed = 1'b0;
      scan_state   = MODE_NAME;
    end else if (c == CH_LBRACK) begin
      add_points(SCORE_CLASS);
      type_allowed = 1'b0;
      scan_state   = MODE_BRACKET;
    end else if (c == CH_COLON) begin
      add_points(SCORE_CLASS);
      type_allowed = 1'b0;
      scan_state   = MODE_COLON;
    end else if (type_allowed && letter_or_mark(c)) begin
      add_points(SCORE_TYPE);
      type_allowed = 1'b0;
      scan_state   = MODE_NAME;
    end else begin
      type_allowed = 1'b0;
    end
  endfunction

  function automatic void track_byte(input in_beat_t b);
    out_beat_t r;
    if (split_char(b.text_byte)) end_selector();
    else score_char(b.text_byte);
    if (b.final_byte) begin
      end_selector();
      r.saturated = score_clipped;
      if (best_score > 64'hFFFF) begin
        r.spec_max  = 16'hFFFF;
        r.saturated = 1'b1;
      end else begin
        r.spec_max = best_score[15:0];
      end
      specificity_q = {specificity_q, r};
      clear_state();
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) track_byte(in_beat);
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (specificity_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: specificity %0d saturated %0b",
                   out_beat.spec_max, out_beat.saturated);
      end else begin
        want = specificity_q.pop_front();
        if (out_beat.spec_max !== want.spec_max ||
            out_beat.saturated !== want.saturated) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected specificity %0d saturated %0b, got %0d %0b",
                     want.spec_max, want.saturated,
                     out_beat.spec_max, out_beat.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("css_selector_list_specificity_top test failed");
      $finish;
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    logic [8:0]  phase;
    int unsigned hold_left;
    phase     = '0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        phase++;
        case (phase[8:7])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= ($urandom_range(0, 1) == 1);
          2'd2: out_ready <= (phase[3:0] < 4'd11);
          default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  function automatic int unsigned pick_burst();
    if ($urandom_range(0, 7) == 0) return $urandom_range(40, 150);
    return $urandom_range(1, 12);
  endfunction

  // called just after a falling edge; returns just after a falling edge
  task automatic send_byte(input logic [7:0] c, input logic last);
    in_beat_t b;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = pick_burst();
    end
    burst_left--;
    b.text_byte  = c;
    b.final_byte = last;
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  task automatic send_list();
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) send_byte(text_q[i], i == n - 1);
    text_q.delete();
  endtask

  task automatic test_directed();
    add_text("a#b.c,[d]:e");
    send_list();
    add_text("::x(y)");
    send_list();
    add_byte(8'hFF);
    send_list();
    add_byte(8'h00);
    send_list();
    // unclosed attribute ends with the list
    add_text("[a");
    send_list();
    add_text(",");
    send_list();
    add_text("'a,");
    send_list();
    add_text("\\,a");
    send_list();
  endtask

  // depths stick at the top, so one fewer closer brings them back to zero
  task automatic test_nesting();
    repeat (NEST_LIMIT + 1) add_byte(CH_LPAREN);
    repeat (NEST_LIMIT) add_byte(CH_RPAREN);
    add_text(",#a");
    send_list();
    repeat (NEST_LIMIT + 1) add_byte(CH_LBRACK);
    repeat (NEST_LIMIT) add_byte(CH_RBRACK);
    add_text(",.b");
    send_list();
  endtask

  task automatic test_overflow();
    add_text("a,");
    repeat (SCORE_LIMIT / SCORE_ID + 4) add_byte(CH_HASH);
    add_text(",p");
    send_list();
  endtask

  task automatic test_backpressure();
    hold_request = 300;
    @(negedge clk);
    repeat (10) begin
      add_text("#x.y ");
      add_byte(8'($urandom_range(0, 255)));
      send_list();
    end
  endtask

  function automatic void add_name();
    repeat ($urandom_range(1, 4))
      add_byte(NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)]);
  endfunction

  function automatic void add_token();
    case ($urandom_range(0, 15))
      0, 15: add_name();
      1: begin add_byte(CH_HASH); add_name(); end
      2: begin add_byte(CH_DOT); add_name(); end
      3: begin
        add_byte(CH_LBRACK);
        add_name();
        if ($urandom_range(0, 1)) add_text("='a,]'");
        add_byte(CH_RBRACK);
      end
      4: begin add_byte(CH_COLON); add_name(); end
      5: begin add_text("::"); add_name(); end
      6: begin
        add_byte(CH_COLON);
        add_name();
        add_text("(.a,b");
        if ($urandom_range(0, 3) != 0) add_byte(CH_RPAREN);
      end
      7: begin
        case ($urandom_range(0, 4))
          0: add_byte(CH_SPACE);
          1: add_byte(CH_GT);
          2: add_byte(CH_PLUS);
          3: add_byte(CH_TILDE);
          default: add_byte(8'($urandom_range(9, 13)));
        endcase
      end
      8: add_byte(CH_COMMA);
      9: begin
        if ($urandom_range(0, 1)) add_text("\"q,\\\"r\"");
        else add_text("'s,\"t'");
      end
      10: begin
        add_byte(CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end
      11: add_byte("*");
      12, 13: add_byte(8'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 2))
          0: add_byte(CH_RPAREN);
          1: add_byte(CH_RBRACK);
          default: add_byte(CH_LPAREN);
        endcase
      end
    endcase
  endfunction

  task automatic test_random();
    int tokens;
    while (random_sent < RANDOM_BYTES) begin
      tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 7);
      repeat (tokens) add_token();
      random_sent += text_q.size();
      send_list();
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    clear_state();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_nesting();
    test_overflow();
    test_backpressure();
    test_random();

    in_valid <= 1'b0;
    while (specificity_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_count == 0 && specificity_q.size() == 0) begin
      $display("css_selector_list_specificity_top test passed");
    end else begin
      $display("css_selector_list_specificity_top test failed");
    end
    $finish;
  end

endmodule
